@@ rtl/core/pfb_pkg.sv @@
// shared constants, types and codes for the page framebuffer rectangle fill unit
`timescale 1ns / 1ps

package pfb_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int PAGE_ROWS    = 8;
    localparam int PAGE_COUNT   = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int COL_W  = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int BIT_W  = $clog2(PAGE_ROWS);

    // fixed field widths of the stream payload
    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 9;
    localparam int SIZE_W   = 8;
    localparam int OCOL_W   = 7;
    localparam int OPAGE_W  = 3;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 24;

    typedef enum logic [FUNC_W-1:0] {
        FN_DRAW  = 2'd0,
        FN_CLEAR = 2'd1,
        FN_SCAN  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    // one access to the frame store: read, clearing write, or merge-write of the last read byte
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              wr_clear;
        logic              wr_set;
        logic [7:0]        wr_mask;
        logic [ADDR_W-1:0] addr;
    } t_mem_cmd;

endpackage

@@ rtl/core/pfb_store.sv @@
// frame store memory with registered read and read-modify-write merge
`timescale 1ns / 1ps

module pfb_store
    import pfb_pkg::*;
(
    input  logic       i_clk,
    input  t_mem_cmd   i_cmd,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_q;
    logic [7:0] n_wdata;

    // merge works on the byte read the cycle before
    always_comb begin
        if (i_cmd.wr_clear) begin
            n_wdata = 8'h00;
        end else if (i_cmd.wr_set) begin
            n_wdata = r_q | i_cmd.wr_mask;
        end else begin
            n_wdata = r_q & ~i_cmd.wr_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.addr] <= n_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_q <= r_mem[i_cmd.addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

@@ rtl/core/page_framebuffer_rect_fill_unit.sv @@
// top level: page framebuffer with rectangle fill, frame clear and byte scan
// scan: byte read on acceptance, registered to the output in the scan state; ready low until the output is free
// draw: a setup state, then a read and a merge-write per touched byte
// clear: one write per byte through the single store port, with ready low
// reset: synchronous, active low; a clearing pass over every byte follows, ready held low
// throughput: one request at a time, the store port sets the pace of draw and clear
`timescale 1ns / 1ps

module page_framebuffer_rect_fill_unit
    import pfb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // rect_x[8:0], rect_y[17:9], rect_width[25:18], rect_height[33:26], pixel_on[34], zeros
    input  logic [IN_DW-1:0]  i_s_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0] i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // pixel_byte[7:0], byte_column[14:8], byte_page[17:15], zeros
    output logic [OUT_DW-1:0] o_m_tdata,
    // frame_last
    output logic              o_m_tlast
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLR   = 6'b000010,
        S_SETUP = 6'b000100,
        S_DRD   = 6'b001000,
        S_DWR   = 6'b010000,
        S_SCAN  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // captured draw request
    logic [COORD_W-1:0] r_x, r_y;
    logic [SIZE_W-1:0]  r_w, r_h;
    logic               r_on;

    // clipped bounds and walk counters
    logic [COL_W-1:0]   r_x0, r_xl, r_col;
    logic [PAGE_W-1:0]  r_p0, r_p1, r_page;
    logic [BIT_W-1:0]   r_b0, r_bl;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [ADDR_W-1:0]  r_scan_pos;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic [OCOL_W-1:0]  r_out_col;
    logic [OPAGE_W-1:0] r_out_page;
    logic               r_out_last;

    t_mem_cmd           s_cmd;
    logic [7:0]         s_rd_data;
    logic               s_accept;
    t_func              s_func;
    logic               s_out_free;

    logic signed [9:0]  s_xs, s_ys, s_xe, s_ye, s_x0, s_y0, s_x1, s_y1, s_xl, s_yl;
    logic               s_empty;
    logic [ADDR_W-1:0]  s_draw_addr;
    logic [BIT_W-1:0]   s_lo, s_hi;
    logic [7:0]         s_mask;
    logic               s_scan_last;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign s_func     = t_func'(i_s_tuser);
    assign s_out_free = !r_out_valid || i_m_tready;

    // clip the captured rectangle to the panel
    always_comb begin
        s_xs = {r_x[COORD_W-1], r_x};
        s_ys = {r_y[COORD_W-1], r_y};
        s_xe = s_xs + $signed({2'b00, r_w});
        s_ye = s_ys + $signed({2'b00, r_h});
        s_x0 = (s_xs < 10'sd0) ? 10'sd0 : s_xs;
        s_y0 = (s_ys < 10'sd0) ? 10'sd0 : s_ys;
        s_x1 = (s_xe > $signed(10'(PANEL_WIDTH)))  ? $signed(10'(PANEL_WIDTH))  : s_xe;
        s_y1 = (s_ye > $signed(10'(PANEL_HEIGHT))) ? $signed(10'(PANEL_HEIGHT)) : s_ye;
        s_xl = s_x1 - 10'sd1;
        s_yl = s_y1 - 10'sd1;
        s_empty = (s_x1 <= s_x0) || (s_y1 <= s_y0);
    end

    // byte address and row mask of the current walk position
    always_comb begin
        s_draw_addr = ADDR_W'(ADDR_W'(r_page) * ADDR_W'(PANEL_WIDTH)) + ADDR_W'(r_col);
        s_lo   = (r_page == r_p0) ? r_b0 : BIT_W'(0);
        s_hi   = (r_page == r_p1) ? r_bl : BIT_W'(PAGE_ROWS - 1);
        s_mask = (8'hFF << s_lo) & (8'hFF >> (BIT_W'(PAGE_ROWS - 1) - s_hi));
    end

    assign s_scan_last = (r_scan_pos == ADDR_W'(STORE_BYTES - 1));

    always_comb begin
        s_cmd          = '0;
        s_cmd.wr_mask  = s_mask;
        s_cmd.wr_set   = r_on;
        s_cmd.addr     = s_draw_addr;
        unique case (r_state)
            S_CLR: begin
                s_cmd.wr_en    = 1'b1;
                s_cmd.wr_clear = 1'b1;
                s_cmd.addr     = r_clr_addr;
            end
            S_DRD: begin
                s_cmd.rd_en = 1'b1;
            end
            S_DWR: begin
                s_cmd.wr_en = 1'b1;
            end
            S_IDLE: begin
                s_cmd.rd_en = s_accept && (s_func == FN_SCAN);
                s_cmd.addr  = r_scan_pos;
            end
            S_SETUP, S_SCAN: begin
            end
            default: begin
            end
        endcase
    end

    pfb_store u_store (
        .i_clk     (i_clk),
        .i_cmd     (s_cmd),
        .o_rd_data (s_rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (s_func)
                        FN_DRAW:  n_state = S_SETUP;
                        FN_CLEAR: n_state = S_CLR;
                        FN_SCAN:  n_state = S_SCAN;
                        FN_NONE:  n_state = S_IDLE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                if (r_clr_addr == ADDR_W'(STORE_BYTES - 1)) n_state = S_IDLE;
            end
            S_SETUP: begin
                n_state = s_empty ? S_IDLE : S_DRD;
            end
            S_DRD: begin
                n_state = S_DWR;
            end
            S_DWR: begin
                if (r_col == r_xl && r_page == r_p1) n_state = S_IDLE;
                else n_state = S_DRD;
            end
            S_SCAN: begin
                if (s_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_scan_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end else begin
                r_clr_addr <= '0;
            end
            if (r_state == S_SCAN && s_out_free) begin
                r_out_valid <= 1'b1;
                r_scan_pos  <= s_scan_last ? '0 : r_scan_pos + ADDR_W'(1);
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x  <= i_s_tdata[8:0];
            r_y  <= i_s_tdata[17:9];
            r_w  <= i_s_tdata[25:18];
            r_h  <= i_s_tdata[33:26];
            r_on <= i_s_tdata[34];
        end
        if (r_state == S_SETUP) begin
            r_x0   <= COL_W'(s_x0);
            r_xl   <= COL_W'(s_xl);
            r_col  <= COL_W'(s_x0);
            r_p0   <= PAGE_W'(s_y0 >>> BIT_W);
            r_p1   <= PAGE_W'(s_yl >>> BIT_W);
            r_page <= PAGE_W'(s_y0 >>> BIT_W);
            r_b0   <= s_y0[BIT_W-1:0];
            r_bl   <= s_yl[BIT_W-1:0];
        end
        // column-minor walk inside each page
        if (r_state == S_DWR) begin
            if (r_col == r_xl) begin
                r_col  <= r_x0;
                r_page <= r_page + PAGE_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
        if (r_state == S_SCAN && s_out_free) begin
            r_out_byte <= s_rd_data;
            r_out_col  <= OCOL_W'(r_scan_pos % ADDR_W'(PANEL_WIDTH));
            r_out_page <= OPAGE_W'(r_scan_pos / ADDR_W'(PANEL_WIDTH));
            r_out_last <= s_scan_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DW'({r_out_page, r_out_col, r_out_byte});
    assign o_m_tlast  = r_out_last;

    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_func == FN_CLEAR) |=> (r_state == S_CLR && r_clr_addr == '0))
        else $error("clear request did not start a sweep at address zero");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DWR) |-> ($past(r_state) == S_DRD))
        else $error("draw merge-write without a preceding read");

    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_func == FN_SCAN) |=> (r_state == S_SCAN))
        else $error("scan request did not enter the scan state");

    a_last_on_final_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
            (r_out_page == OPAGE_W'(PAGE_COUNT - 1) && r_out_col == OCOL_W'(PANEL_WIDTH - 1)))
        else $error("frame end flagged away from the final byte");

    a_ready_blocked_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_s_tready)
        else $error("request taken during the clearing sweep");

endmodule
